@@ rtl/core/csp_pkg.sv @@
// Shared types, constants and arithmetic helpers for the cubic spline evaluator.
// Used by every module under rtl/core except csp_ram; depends on nothing else.
package csp_pkg;

  // Table geometry
  localparam int MAX_POINTS  = 256;
  localparam int DIMENSION   = 4;
  localparam int ENTRY_COUNT = MAX_POINTS * DIMENSION;
  localparam int ADDR_W      = $clog2(ENTRY_COUNT);
  localparam int SAMPLE_W    = 16;

  // Slave tdata layout (lowest bit first)
  localparam int IN_TDATA_W   = 56;
  localparam int IN_PIDX_LSB  = 0;
  localparam int IN_COMP_LSB  = 8;
  localparam int IN_SAMP_LSB  = 10;
  localparam int IN_POS_LSB   = 26;
  localparam int IN_ORD_LSB   = 43;
  localparam int IN_FIRST_LSB = 45;
  localparam int IN_COUNT_LSB = 47;

  // Master tdata layout (lowest bit first)
  localparam int OUT_TDATA_W    = 40;
  localparam int OUT_VALUE_LSB  = 0;
  localparam int OUT_COMP_LSB   = 32;
  localparam int OUT_STATUS_BIT = 34;

  // Configuration register indexes
  localparam logic [1:0] CFG_SPLINE_KIND = 2'd0;
  localparam logic [1:0] CFG_POINT_COUNT = 2'd1;
  localparam logic [1:0] CFG_TENSION     = 2'd2;

  // Spline kinds
  localparam logic [1:0] SPL_BEZIER  = 2'd0;
  localparam logic [1:0] SPL_CATMULL = 2'd1;
  localparam logic [1:0] SPL_BSPLINE = 2'd2;

  // Derivative orders
  localparam logic [1:0] ORD_VALUE  = 2'd0;
  localparam logic [1:0] ORD_FIRST  = 2'd1;
  localparam logic [1:0] ORD_SECOND = 2'd2;

  // Request kinds (tuser)
  localparam logic ITEM_WRITE = 1'b0;
  localparam logic ITEM_EVAL  = 1'b1;

  // Status codes
  localparam logic STATUS_OK  = 1'b0;
  localparam logic STATUS_BAD = 1'b1;

  localparam logic [16:0] POS_ONE = 17'h10000;
  // ceil(2^22 / 6): exact floor division by 6 below 2^21
  localparam logic [19:0] RECIP6  = 20'd699051;
  // ceil(2^9 / 3): exact floor division by 3 below 2^9
  localparam logic [8:0]  RECIP3  = 9'd171;

  typedef logic signed [17:0] q16_t;   // 0 .. 1.0 in Q16
  typedef logic signed [22:0] opd_t;   // product operand, Q16
  typedef logic signed [24:0] wgt_t;   // basis weight, Q16
  typedef logic [7:0]         pidx_t;
  typedef logic [1:0]         comp_t;

  localparam opd_t O_ONE   = 23'sd65536;
  localparam opd_t O_TWO   = 23'sd131072;
  localparam opd_t O_THREE = 23'sd196608;
  localparam opd_t O_SIX   = 23'sd393216;
  localparam wgt_t W_ONE   = 25'sd65536;

  // One component operation travelling down the pipeline
  typedef struct packed {
    logic                       is_eval;
    logic                       bad;
    logic                       last;
    comp_t                      comp;
    pidx_t                      pidx;
    logic signed [SAMPLE_W-1:0] sample;
    logic [16:0]                pos;
    logic [1:0]                 order;
    logic [7:0]                 nseg;
  } uop_t;

  // Result tag once the weights are known
  typedef struct packed {
    logic  is_eval;
    logic  bad;
    logic  last;
    comp_t comp;
  } tag_t;

  // Q16 product rounded to Q16: add half, floor shift
  function automatic opd_t qmul(opd_t x, q16_t y);
    logic signed [40:0] p;
    logic signed [40:0] r;
    p = x * y;
    r = (p + 41'sd32768) >>> 16;
    return r[22:0];
  endfunction

  function automatic opd_t oq(q16_t x);
    return opd_t'(x);
  endfunction

  function automatic wgt_t wq(q16_t x);
    return wgt_t'(x);
  endfunction

  function automatic wgt_t wo(opd_t x);
    return wgt_t'(x);
  endfunction

endpackage

@@ rtl/core/csp_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// Stand-alone; no package needed.
module csp_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ rtl/core/csp_split.sv @@
// Request intake: checks the configuration and component window, and
// splits each evaluate request into one operation per component. Uses csp_pkg.
module csp_split import csp_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  adv,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [IN_TDATA_W-1:0] s_tdata,
  input  logic                  s_tuser,
  input  logic [1:0]            spline_kind,
  input  logic [8:0]            point_count,
  output logic                  op_valid,
  output uop_t                  op
);

  logic [7:0]  in_pidx;
  comp_t       in_comp;
  logic [15:0] in_sample;
  logic [16:0] in_pos;
  logic [1:0]  in_order;
  comp_t       in_first;
  logic [2:0]  in_count;
  logic [8:0]  pm1;
  logic [16:0] q3_full;
  logic [7:0]  q3;
  logic        bad_cfg;
  logic        bad_win;
  logic        bad;
  logic        last_part;
  logic [1:0]  sub;
  uop_t        op_next;

  // Unpack the request
  assign in_pidx   = s_tdata[IN_PIDX_LSB +: 8];
  assign in_comp   = s_tdata[IN_COMP_LSB +: 2];
  assign in_sample = s_tdata[IN_SAMP_LSB +: 16];
  assign in_pos    = s_tdata[IN_POS_LSB +: 17];
  assign in_order  = s_tdata[IN_ORD_LSB +: 2];
  assign in_first  = s_tdata[IN_FIRST_LSB +: 2];
  assign in_count  = s_tdata[IN_COUNT_LSB +: 3];

  // Segment count and configuration check
  assign pm1     = point_count - 9'd1;
  assign q3_full = 17'(pm1[7:0]) * 17'(RECIP3);
  assign q3      = q3_full[16:9];
  assign bad_cfg = (point_count < 9'd4) || (point_count > 9'(MAX_POINTS))
                || (spline_kind != SPL_BEZIER && spline_kind != SPL_CATMULL
                    && spline_kind != SPL_BSPLINE)
                || (spline_kind == SPL_BEZIER && pm1 != 9'(10'(q3) * 10'd3));
  assign bad_win = (in_count == 3'd0)
                || ((5'(in_first) + 5'(in_count)) > 5'(DIMENSION));
  assign bad     = bad_cfg || bad_win;

  assign last_part = (s_tuser == ITEM_WRITE) || bad || ({1'b0, sub} == in_count - 3'd1);
  assign s_tready  = adv && last_part;

  // Build the component operation
  always_comb begin
    op_next         = '0;
    op_next.is_eval = (s_tuser == ITEM_EVAL);
    op_next.pidx    = in_pidx;
    op_next.sample  = signed'(in_sample);
    op_next.pos     = (in_pos > POS_ONE) ? POS_ONE : in_pos;
    op_next.order   = (in_order == 2'd3) ? ORD_SECOND : in_order;
    op_next.nseg    = (spline_kind == SPL_BEZIER) ? q3 : pm1[7:0];
    if (s_tuser == ITEM_WRITE) begin
      op_next.comp = in_comp;
    end else if (bad) begin
      op_next.bad  = 1'b1;
      op_next.last = 1'b1;
      op_next.comp = '0;
    end else begin
      op_next.comp = in_first + sub;
      op_next.last = last_part;
    end
  end

  // Advance the component counter and the operation register
  always_ff @(posedge clk) begin
    if (rst) begin
      sub      <= '0;
      op_valid <= 1'b0;
    end else if (adv) begin
      op_valid <= s_tvalid;
      if (s_tvalid) begin
        sub <= last_part ? 2'd0 : sub + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      op <= op_next;
    end
  end

endmodule

@@ rtl/core/csp_weights.sv @@
// Basis weight pipeline: segment and local parameter, powers of u and 1-u,
// kind-specific products and the four weights, five register stages. Uses csp_pkg.
module csp_weights import csp_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        adv,
  input  logic [1:0]  spline_kind,
  input  logic [8:0]  point_count,
  input  logic [15:0] tension,
  input  logic        op_valid,
  input  uop_t        op,
  output logic        st5_valid,
  output uop_t        st5_op,
  output pidx_t       st5_idx [4],
  output wgt_t        st5_w [4]
);

  // Stage 1: segment and local parameter
  logic [23:0] t;
  logic [7:0]  seg_raw;
  logic        seg_clamp;
  logic        st1_valid;
  uop_t        st1_op;
  logic [7:0]  st1_seg;
  q16_t        st1_u;

  assign t         = 24'(op.nseg) * 24'(op.pos);
  assign seg_raw   = t[23:16];
  assign seg_clamp = (seg_raw >= op.nseg);

  always_ff @(posedge clk) begin
    if (adv) begin
      st1_op  <= op;
      st1_seg <= seg_clamp ? op.nseg - 8'd1 : seg_raw;
      st1_u   <= seg_clamp ? q16_t'(POS_ONE) : q16_t'({1'b0, t[15:0]});
    end
  end

  // Stage 2: squares, tension scale and point indexes
  q16_t  v_c;
  pidx_t idx_c [4];
  pidx_t base3;
  logic  st2_valid;
  uop_t  st2_op;
  q16_t  st2_u, st2_u2, st2_v, st2_v2;
  opd_t  st2_a;
  pidx_t st2_idx [4];

  assign v_c   = q16_t'(POS_ONE) - st1_u;
  assign base3 = {st1_seg[6:0], 1'b0} + st1_seg;

  always_comb begin
    if (spline_kind == SPL_BEZIER) begin
      for (int k = 0; k < 4; k++) begin
        idx_c[k] = base3 + 8'(k);
      end
    end else begin
      idx_c[0] = (st1_seg == 8'd0) ? 8'd0 : st1_seg - 8'd1;
      idx_c[1] = st1_seg;
      idx_c[2] = st1_seg + 8'd1;
      idx_c[3] = ({1'b0, st1_seg} == point_count - 9'd2) ? st1_seg + 8'd1 : st1_seg + 8'd2;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      st2_op  <= st1_op;
      st2_u   <= st1_u;
      st2_v   <= v_c;
      st2_u2  <= q16_t'(qmul(oq(st1_u), st1_u));
      st2_v2  <= q16_t'(qmul(oq(v_c), v_c));
      st2_a   <= opd_t'(signed'(tension)) <<< 4;
      st2_idx <= idx_c;
    end
  end

  // Stage 3: cubes and the first level of kind-specific products
  opd_t px [4];
  q16_t py [4];
  logic st3_valid;
  uop_t st3_op;
  q16_t st3_u, st3_u2, st3_u3, st3_v, st3_v2, st3_v3;
  opd_t st3_a;
  opd_t st3_p [4];
  pidx_t st3_idx [4];

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      px[i] = '0;
      py[i] = '0;
    end
    case (spline_kind)
      SPL_BEZIER: begin
        case (st2_op.order)
          ORD_VALUE: begin
            px[0] = oq(st2_u);  py[0] = st2_v2;
            px[1] = oq(st2_u2); py[1] = st2_v;
          end
          ORD_FIRST: begin
            px[0] = O_THREE - 23'sd9 * oq(st2_u); py[0] = st2_v;
            px[1] = O_SIX - 23'sd9 * oq(st2_u);   py[1] = st2_u;
          end
          default: ;
        endcase
      end
      SPL_CATMULL: begin
        case (st2_op.order)
          ORD_VALUE: begin
            px[0] = st2_a;                      py[0] = st2_u2;
            px[1] = st2_a;                      py[1] = st2_u;
            px[2] = st2_a - O_THREE;            py[2] = st2_u2;
            px[3] = O_THREE - (st2_a <<< 1);    py[3] = st2_u2;
          end
          ORD_FIRST: begin
            px[0] = st2_a;                      py[0] = st2_u2;
            px[1] = st2_a;                      py[1] = st2_u;
            px[2] = O_TWO - st2_a;              py[2] = st2_u2;
            px[3] = st2_a - O_THREE;            py[3] = st2_u;
          end
          default: begin
            px[0] = st2_a;                      py[0] = st2_u;
            px[1] = O_TWO - st2_a;              py[1] = st2_u;
            px[2] = st2_a - O_TWO;              py[2] = st2_u;
          end
        endcase
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      st3_op  <= st2_op;
      st3_u   <= st2_u;
      st3_u2  <= st2_u2;
      st3_v   <= st2_v;
      st3_v2  <= st2_v2;
      st3_a   <= st2_a;
      st3_idx <= st2_idx;
      st3_u3  <= q16_t'(qmul(oq(st2_u2), st2_u));
      st3_v3  <= q16_t'(qmul(oq(st2_v2), st2_v));
      for (int i = 0; i < 4; i++) begin
        st3_p[i] <= qmul(px[i], py[i]);
      end
    end
  end

  // Stage 4: products against u^3, u^2 and u, and B-spline numerators
  opd_t qx [3];
  q16_t qy [3];
  wgt_t bs [4];
  logic st4_valid;
  uop_t st4_op;
  q16_t st4_u, st4_u2, st4_u3, st4_v, st4_v2, st4_v3;
  opd_t st4_a;
  opd_t st4_p [4];
  opd_t st4_q [3];
  logic [19:0] st4_b [4];
  pidx_t st4_idx [4];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      qx[i] = '0;
      qy[i] = '0;
    end
    if (spline_kind == SPL_CATMULL && st3_op.order == ORD_VALUE) begin
      qx[0] = st3_a;          qy[0] = st3_u3;
      qx[1] = O_TWO - st3_a;  qy[1] = st3_u3;
      qx[2] = st3_a - O_TWO;  qy[2] = st3_u3;
    end else if (spline_kind == SPL_CATMULL && st3_op.order == ORD_FIRST) begin
      qx[0] = st3_a - O_TWO;             qy[0] = st3_u2;
      qx[1] = O_THREE - (st3_a <<< 1);   qy[1] = st3_u;
    end
    // rounding offset of the divide by six folded in
    bs[0] = wq(st3_v3) + 25'sd3;
    bs[1] = 25'sd3 * wq(st3_u3) - 25'sd6 * wq(st3_u2) + (W_ONE <<< 2) + 25'sd3;
    bs[2] = 25'sd3 * (wq(st3_u2) + wq(st3_u) - wq(st3_u3)) + W_ONE + 25'sd3;
    bs[3] = wq(st3_u3) + 25'sd3;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      st4_op  <= st3_op;
      st4_u   <= st3_u;
      st4_u2  <= st3_u2;
      st4_u3  <= st3_u3;
      st4_v   <= st3_v;
      st4_v2  <= st3_v2;
      st4_v3  <= st3_v3;
      st4_a   <= st3_a;
      st4_p   <= st3_p;
      st4_idx <= st3_idx;
      for (int i = 0; i < 3; i++) begin
        st4_q[i] <= qmul(qx[i], qy[i]);
      end
      for (int i = 0; i < 4; i++) begin
        st4_b[i] <= bs[i][19:0];
      end
    end
  end

  // Stage 5: combine into the four weights
  function automatic wgt_t div6(logic [19:0] b);
    logic [39:0] m;
    m = 40'(b) * 40'(RECIP6);
    return wgt_t'({7'b0, m[39:22]});
  endfunction

  wgt_t w_c [4];
  wgt_t wa;

  assign wa = wo(st4_a);

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      w_c[k] = '0;
    end
    case (spline_kind)
      SPL_BEZIER: begin
        case (st4_op.order)
          ORD_VALUE: begin
            w_c[0] = wq(st4_v3);
            w_c[1] = 25'sd3 * wo(st4_p[0]);
            w_c[2] = 25'sd3 * wo(st4_p[1]);
            w_c[3] = wq(st4_u3);
          end
          ORD_FIRST: begin
            w_c[0] = -25'sd3 * wq(st4_v2);
            w_c[1] = wo(st4_p[0]);
            w_c[2] = wo(st4_p[1]);
            w_c[3] = 25'sd3 * wq(st4_u2);
          end
          default: begin
            w_c[0] = 25'sd6 * wq(st4_v);
            w_c[1] = 25'sd18 * wq(st4_u) - 25'sd12 * W_ONE;
            w_c[2] = 25'sd6 * W_ONE - 25'sd18 * wq(st4_u);
            w_c[3] = 25'sd6 * wq(st4_u);
          end
        endcase
      end
      SPL_CATMULL: begin
        case (st4_op.order)
          ORD_VALUE: begin
            w_c[0] = (wo(st4_p[0]) <<< 1) - wo(st4_q[0]) - wo(st4_p[1]);
            w_c[1] = wo(st4_q[1]) + wo(st4_p[2]) + W_ONE;
            w_c[2] = wo(st4_q[2]) + wo(st4_p[3]) + wo(st4_p[1]);
            w_c[3] = wo(st4_q[0]) - wo(st4_p[0]);
          end
          ORD_FIRST: begin
            w_c[0] = 25'sd4 * wo(st4_p[1]) - 25'sd3 * wo(st4_p[0]) - wa;
            w_c[1] = 25'sd3 * wo(st4_p[2]) + 25'sd2 * wo(st4_p[3]);
            w_c[2] = 25'sd3 * wo(st4_q[0]) + 25'sd2 * wo(st4_q[1]) + wa;
            w_c[3] = 25'sd3 * wo(st4_p[0]) - 25'sd2 * wo(st4_p[1]);
          end
          default: begin
            w_c[0] = 25'sd4 * wa - 25'sd6 * wo(st4_p[0]);
            w_c[1] = 25'sd6 * wo(st4_p[1]) + 25'sd2 * (wa - 25'sd3 * W_ONE);
            w_c[2] = 25'sd6 * wo(st4_p[2]) + 25'sd2 * (25'sd3 * W_ONE - (wa <<< 1));
            w_c[3] = 25'sd6 * wo(st4_p[0]) - (wa <<< 1);
          end
        endcase
      end
      SPL_BSPLINE: begin
        case (st4_op.order)
          ORD_VALUE: begin
            for (int k = 0; k < 4; k++) begin
              w_c[k] = div6(st4_b[k]);
            end
          end
          ORD_FIRST: begin
            w_c[0] = (25'sd1 - wq(st4_v2)) >>> 1;
            w_c[1] = (25'sd3 * wq(st4_u2) - 25'sd4 * wq(st4_u) + 25'sd1) >>> 1;
            w_c[2] = (25'sd2 * wq(st4_u) - 25'sd3 * wq(st4_u2) + W_ONE + 25'sd1) >>> 1;
            w_c[3] = (wq(st4_u2) + 25'sd1) >>> 1;
          end
          default: begin
            w_c[0] = wq(st4_v);
            w_c[1] = 25'sd3 * wq(st4_u) - 25'sd2 * W_ONE;
            w_c[2] = W_ONE - 25'sd3 * wq(st4_u);
            w_c[3] = wq(st4_u);
          end
        endcase
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      st5_op  <= st4_op;
      st5_idx <= st4_idx;
      st5_w   <= w_c;
    end
  end

  // Valid bits follow the data
  always_ff @(posedge clk) begin
    if (rst) begin
      st1_valid <= 1'b0;
      st2_valid <= 1'b0;
      st3_valid <= 1'b0;
      st4_valid <= 1'b0;
      st5_valid <= 1'b0;
    end else if (adv) begin
      st1_valid <= op_valid;
      st2_valid <= st1_valid;
      st3_valid <= st2_valid;
      st4_valid <= st3_valid;
      st5_valid <= st4_valid;
    end
  end

endmodule

@@ rtl/core/csp_mac.sv @@
// Control point tables, weight-times-point products, sum, rounding and
// saturation, and the result register. Uses csp_pkg and csp_ram.
module csp_mac import csp_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  output logic                   adv,
  input  logic                   st5_valid,
  input  uop_t                   st5_op,
  input  pidx_t                  st5_idx [4],
  input  wgt_t                   st5_w [4],
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [OUT_TDATA_W-1:0] m_tdata,
  output logic                   m_tlast
);

  logic [SAMPLE_W-1:0] rdata [4];
  logic                we;
  logic [ADDR_W-1:0]   waddr;

  // The whole pipeline moves when the result register is free
  assign adv   = !m_tvalid || m_tready;
  assign we    = adv && st5_valid && !st5_op.is_eval;
  assign waddr = {st5_op.pidx, st5_op.comp};

  // One table copy per basis tap, all written alike
  for (genvar k = 0; k < 4; k++) begin : g_tap
    csp_ram #(
      .WIDTH (SAMPLE_W),
      .DEPTH (ENTRY_COUNT)
    ) u_ram (
      .clk   (clk),
      .we    (we),
      .waddr (waddr),
      .wdata (st5_op.sample),
      .re    (adv),
      .raddr ({st5_idx[k], st5_op.comp}),
      .rdata (rdata[k])
    );
  end

  // Stage 6: weights wait beside the table read
  logic st6_valid;
  tag_t st6_tag;
  wgt_t st6_w [4];

  always_ff @(posedge clk) begin
    if (adv) begin
      st6_tag <= '{is_eval: st5_op.is_eval, bad: st5_op.bad, last: st5_op.last,
                   comp: st5_op.comp};
      st6_w   <= st5_w;
    end
  end

  // Stage 7: four products
  logic signed [40:0] prod_c [4];
  logic signed [40:0] st7_prod [4];
  logic               st7_valid;
  tag_t               st7_tag;

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      prod_c[k] = st6_w[k] * signed'(rdata[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      st7_tag  <= st6_tag;
      st7_prod <= prod_c;
    end
  end

  // Stage 8: sum, round to 8 fractional bits, saturate
  logic signed [42:0] sum;
  logic signed [42:0] rnd;
  logic [31:0]        value;

  assign sum = 43'(st7_prod[0]) + 43'(st7_prod[1]) + 43'(st7_prod[2]) + 43'(st7_prod[3]);
  assign rnd = (sum + 43'sd128) >>> 8;

  always_comb begin
    if (st7_tag.bad) begin
      value = '0;
    end else if (rnd > 43'sd2147483647) begin
      value = 32'h7FFF_FFFF;
    end else if (rnd < -43'sd2147483648) begin
      value = 32'h8000_0000;
    end else begin
      value = rnd[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m_tdata <= {5'b0, (st7_tag.bad ? STATUS_BAD : STATUS_OK), st7_tag.comp, value};
      m_tlast <= st7_tag.last;
    end
  end

  // Valid bits; write requests end at the table
  always_ff @(posedge clk) begin
    if (rst) begin
      st6_valid <= 1'b0;
      st7_valid <= 1'b0;
      m_tvalid  <= 1'b0;
    end else if (adv) begin
      st6_valid <= st5_valid && st5_op.is_eval;
      st7_valid <= st6_valid;
      m_tvalid  <= st7_valid;
    end
  end

endmodule

@@ rtl/core/cubic_spline_evaluator.sv @@
// Cubic spline evaluator top level: configuration registers and the pipeline.
// Depends on csp_pkg, csp_split, csp_weights, csp_mac and csp_ram.
//
//  channel | dir | handshake          | content
//  s_*     | in  | s_tvalid/s_tready  | tdata: request fields, tuser: kind
//  m_*     | out | m_tvalid/m_tready  | tdata: value, component, status; tlast
//  cfg_*   | in  | cfg_we             | register index and data, no read-back
//
// An evaluate request holds the input until every component in its
// window (one to four) is issued; write requests and error results are one operation.
// Each tap table has a single read port; the pipeline carries one component
// per cycle while no result is held.
// Reset clears the registers to Bezier, four points, tension 0.5; the point
// table is not cleared. A stalled result stalls the whole pipeline in place.
module cubic_spline_evaluator import csp_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  // point_index, component, sample, position, derivative_order,
  // first_component, component_count, zero pad
  input  logic [IN_TDATA_W-1:0]  s_tdata,
  // kind
  input  logic                   s_tuser,
  output logic                   m_tvalid,
  input  logic                   m_tready,
  // result_value, result_component, status, zero pad
  output logic [OUT_TDATA_W-1:0] m_tdata,
  output logic                   m_tlast,
  input  logic                   cfg_we,
  input  logic [1:0]             cfg_index,
  input  logic [15:0]            cfg_data
);

  logic [1:0]  spline_kind;
  logic [8:0]  point_count;
  logic [15:0] tension;
  logic        adv;
  logic        op_valid;
  uop_t        op;
  logic        st5_valid;
  uop_t        st5_op;
  pidx_t       st5_idx [4];
  wgt_t        st5_w [4];

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      spline_kind <= SPL_BEZIER;
      point_count <= 9'd4;
      tension     <= 16'd2048;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SPLINE_KIND: spline_kind <= cfg_data[1:0];
        CFG_POINT_COUNT: point_count <= cfg_data[8:0];
        CFG_TENSION:     tension     <= cfg_data;
        default: ;
      endcase
    end
  end

  csp_split u_split (
    .clk         (clk),
    .rst         (rst),
    .adv         (adv),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .s_tuser     (s_tuser),
    .spline_kind (spline_kind),
    .point_count (point_count),
    .op_valid    (op_valid),
    .op          (op)
  );

  csp_weights u_weights (
    .clk         (clk),
    .rst         (rst),
    .adv         (adv),
    .spline_kind (spline_kind),
    .point_count (point_count),
    .tension     (tension),
    .op_valid    (op_valid),
    .op          (op),
    .st5_valid   (st5_valid),
    .st5_op      (st5_op),
    .st5_idx     (st5_idx),
    .st5_w       (st5_w)
  );

  csp_mac u_mac (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .st5_valid (st5_valid),
    .st5_op    (st5_op),
    .st5_idx   (st5_idx),
    .st5_w     (st5_w),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast)
  );

`ifndef NO_ASSERTIONS
  // An error result is a lone, zero-valued result for component zero
  a_bad_result: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[OUT_STATUS_BIT] |->
      m_tlast && m_tdata[OUT_STATUS_BIT-1:0] == '0)
    else $error("error result carries data");

  // A held result blocks the intake
  a_stall_blocks_input: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |-> !s_tready)
    else $error("request taken while result held");

  // Reset empties the result register
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result valid after reset");
`endif

endmodule
